@@ rtl/core/awe_pkg.sv @@
package awe_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ENV_W       = 24;
  localparam int SVF_W       = 32;
  localparam int CFG_W       = 25;
  localparam int CFG_AW      = 3;
  localparam int MUL_W       = 34;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIV_DW      = 54;
  localparam int DIV_VW      = 37;
  localparam int F_W         = 30;
  localparam int Q_W         = 20;
  localparam int X2_W        = 31;
  localparam int MIX_W       = SAMPLE_BITS + 18;

  typedef enum logic [CFG_AW-1:0] {
    REG_ATTACK,
    REG_RELEASE,
    REG_SENS,
    REG_BASE,
    REG_RANGE,
    REG_RESQ,
    REG_MIX,
    REG_SRATE
  } reg_idx_e;

  localparam logic [CFG_W-1:0] ONE_Q24 = CFG_W'(16777216);
  localparam logic [16:0]      ONE_Q16 = 17'd65536;

  localparam logic signed [PROD_W-1:0] ENV_FULL = PROD_W'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [PROD_W-1:0] CUT_MIN  = PROD_W'(20 * 65536);
  localparam logic signed [PROD_W-1:0] CUT_MAX  = PROD_W'(18000 * 65536);
  localparam logic signed [PROD_W-1:0] F_MAX    = PROD_W'(1052266988);
  localparam logic signed [PROD_W-1:0] Q_MIN    = PROD_W'(6554);

  // sine polynomial, Q30
  localparam logic signed [31:0] HC1 = 32'sd1686629713;
  localparam logic signed [31:0] HC3 = -32'sd693598668;
  localparam logic signed [31:0] HC5 = 32'sd85569306;
  localparam logic signed [31:0] HC7 = -32'sd5026995;
  localparam logic signed [31:0] HC9 = 32'sd172272;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] horner_coef(input logic [1:0] step);
    case (step)
      2'd0:    return HC7;
      2'd1:    return HC5;
      2'd2:    return HC3;
      default: return HC1;
    endcase
  endfunction

  // divide by 2^n, rounding toward zero
  function automatic logic signed [PROD_W-1:0] tdiv_p2(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned n);
    logic signed [PROD_W-1:0] bias;
    bias = v[PROD_W-1] ? $signed((PROD_W'(1) << n) - PROD_W'(1)) : '0;
    return (v + bias) >>> n;
  endfunction

  function automatic logic signed [PROD_W-1:0] sat_s(input logic signed [PROD_W-1:0] v,
                                                     input int unsigned bits);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = $signed((PROD_W'(1) << (bits - 1)) - PROD_W'(1));
    lo = -hi - $signed(PROD_W'(1));
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

endpackage

@@ rtl/core/awe_in_if.sv @@
interface awe_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    channel;
  logic signed [awe_pkg::SAMPLE_BITS-1:0]  sample_in;
  logic                                    last_in_block;

  modport source(output valid, channel, sample_in, last_in_block, input ready);
  modport sink(input valid, channel, sample_in, last_in_block, output ready);
endinterface

@@ rtl/core/awe_out_if.sv @@
interface awe_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [awe_pkg::SAMPLE_BITS-1:0]  sample_out;
  logic                                    channel_out;
  logic [awe_pkg::ENV_W-1:0]               meter_level;
  logic                                    block_done;

  modport source(output valid, sample_out, channel_out, meter_level, block_done, input ready);
  modport sink(input valid, sample_out, channel_out, meter_level, block_done, output ready);
endinterface

@@ rtl/core/awe_div.sv @@
module awe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  awe_pkg::div_req_t req_i,
  output awe_pkg::div_rsp_t rsp_o
);
  import awe_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_DW-1:0] quo_q, quo_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_VW-1:0] dsr_q, dsr_d;
  logic [DIV_VW:0]   rem_sh;
  logic [DIV_VW:0]   rem_sub;

  // restoring, one quotient bit per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    rem_sh  = {rem_q, quo_q[DIV_DW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sub[DIV_VW-1:0];
        quo_d = {quo_q[DIV_DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_VW-1:0];
        quo_d = {quo_q[DIV_DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/core/auto_wah_envelope_svf.sv @@
// Envelope-driven auto-wah: per channel, a one-pole attack/release envelope of |x| steers
// the cutoff of a Chamberlin state-variable filter, and the output blends the dry sample with
// the band-pass by wet_mix. One sample is processed at a time; in_i.ready is low from the
// accepted transaction until its result is loaded into the output register. The time from
// one accept to the next is set by three waits on the shared radix-2 divider (cutoff phase,
// Q limit, damping term; 54 quotient bits each), the Q-limit wait being skipped when the
// tuning coefficient clamps to zero, and by the sequencer steps around the shared 34x34
// multiplier. A result waiting in the output register does not block acceptance of the next
// sample, only its completion.
// Configuration writes are taken at any time but belong between transactions.
module auto_wah_envelope_svf #(
  parameter int CHANNELS        = 2,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [awe_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [awe_pkg::CFG_W-1:0]   cfg_wdata_i,
  awe_in_if.sink                      in_i,
  awe_out_if.source                   out_o
);
  import awe_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int K_W   = TB + 1;
  localparam int X2_SH = 30 - 2 * TB;
  localparam int X_SH  = 30 - TB;

  typedef enum logic [4:0] {
    S_IDLE, S_ENV, S_ENV2, S_CUT1, S_CUT2, S_PHASE, S_X2, S_HORN, S_SIN,
    S_QM, S_QMW, S_SVF0, S_LOW, S_HW, S_BAND, S_MIX1, S_MIX2, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] attack_q, release_q;
  logic [16:0]      sens_q, mix_q;
  logic [9:0]       base_q;
  logic [12:0]      range_q;
  logic [11:0]      resq_q;
  logic [17:0]      srate_q;

  logic [ENV_W-1:0]        env_mem_q  [CHANNELS];
  logic signed [SVF_W-1:0] low_mem_q  [CHANNELS];
  logic signed [SVF_W-1:0] band_mem_q [CHANNELS];
  logic [ENV_W-1:0]        peak_q;
  logic                    fresh_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_ch_q;
  logic [ENV_W-1:0]              out_meter_q;
  logic                          out_done_q;

  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                          ch_q, ch_d;
  logic                          last_q, last_d;
  logic                          active_q, active_d;
  logic [ENV_W-1:0]              env_q, env_d;
  logic [K_W-1:0]                k_q, k_d;
  logic                          neg_q, neg_d;
  logic [X2_W-1:0]               x2_q, x2_d;
  logic [1:0]                    hcnt_q, hcnt_d;
  logic [F_W-1:0]                f_q, f_d;
  logic [Q_W-1:0]                q_q, q_d;
  logic signed [SVF_W-1:0]       low_q, low_d;
  logic signed [SVF_W-1:0]       band_q, band_d;
  logic                          hneg_q, hneg_d;
  logic signed [MIX_W-1:0]       mixacc_q, mixacc_d;
  logic signed [SAMPLE_BITS-1:0] y_q, y_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [MUL_W-1:0]       mul_a, mul_b;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CH_W-1:0]          ch_idx;
  logic signed [PROD_W-1:0] x_w, ax_w, env_old_w, low_old_w, band_old_w;
  logic [CFG_W-1:0]         coef_raw, coef_w;
  logic [16:0]              sens_sat, mix_sat;
  logic [17:0]              sr_nz;
  logic [31:0]              phase_w;
  logic [TB+1:0]            idx_w;
  logic [K_W-1:0]           k_w;
  logic                     load_out;
  logic [ENV_W-1:0]         peak_next;

  awe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ch_idx     = CH_W'(ch_q);
  assign x_w        = PROD_W'(x_q);
  assign ax_w       = x_q[SAMPLE_BITS-1] ? -x_w : x_w;
  assign env_old_w  = PROD_W'(env_mem_q[ch_idx]);
  assign low_old_w  = PROD_W'(low_mem_q[ch_idx]);
  assign band_old_w = PROD_W'(band_mem_q[ch_idx]);
  assign coef_raw   = (ax_w > env_old_w) ? attack_q : release_q;
  assign coef_w     = (coef_raw > ONE_Q24) ? ONE_Q24 : coef_raw;
  assign sens_sat   = (sens_q > ONE_Q16) ? ONE_Q16 : sens_q;
  assign mix_sat    = (mix_q > ONE_Q16) ? ONE_Q16 : mix_q;
  assign sr_nz      = (srate_q == '0) ? 18'd1 : srate_q;

  // quarter-wave fold of the phase
  assign phase_w = div_rsp.quotient[31:0];
  assign idx_w   = phase_w[31 -: TB + 2];
  assign k_w     = idx_w[TB] ? ((K_W'(1) << TB) - K_W'(idx_w[TB-1:0]))
                             : K_W'(idx_w[TB-1:0]);

  assign prod_d = mul_a * mul_b;

  assign load_out  = (state_q == S_OUT) && (!out_valid_q || out_o.ready);
  assign peak_next = (active_q && !ch_q && (fresh_q || env_q > peak_q)) ? env_q : peak_q;

  always_comb begin
    logic signed [PROD_W-1:0] env_tmp, env_new, cut_v, x2_v, acc_v, xk_v, s_v, f_v;
    logic signed [PROD_W-1:0] q_v, num_v, nq_v, dq_v, fq_v, dvs_v, babs_v, bq_v;
    logic signed [PROD_W-1:0] high_v, low_v, band_v, sum_v, y_v;

    env_tmp = env_old_w + tdiv_p2(prod_q, 24);
    env_new = (env_tmp < 0) ? '0 : ((env_tmp > ENV_FULL) ? ENV_FULL : env_tmp);
    cut_v   = (PROD_W'(base_q) << 16) + (prod_q >>> (SAMPLE_BITS - 1));
    cut_v   = (cut_v < CUT_MIN) ? CUT_MIN : ((cut_v > CUT_MAX) ? CUT_MAX : cut_v);
    x2_v    = prod_q <<< X2_SH;
    acc_v   = PROD_W'(horner_coef(hcnt_q)) + tdiv_p2(prod_q, 30);
    xk_v    = PROD_W'(k_q) << X_SH;
    s_v     = tdiv_p2(prod_q, 30) <<< 1;
    f_v     = neg_q ? -s_v : s_v;
    f_v     = (f_v < 0) ? '0 : ((f_v > F_MAX) ? F_MAX : f_v);
    q_v     = PROD_W'(resq_q) << 8;
    q_v     = (q_v < Q_MIN) ? Q_MIN : q_v;
    num_v   = (PROD_W'(1) << 62) - prod_q;
    nq_v    = num_v >>> 15;
    dq_v    = (nq_v <<< 5) + (nq_v <<< 4) + nq_v;
    fq_v    = PROD_W'(f_q);
    dvs_v   = (fq_v <<< 5) + (fq_v <<< 4) + (fq_v <<< 1);
    babs_v  = (band_old_w < 0) ? -band_old_w : band_old_w;
    bq_v    = PROD_W'(div_rsp.quotient);
    if (hneg_q) begin
      bq_v = -bq_v;
    end
    high_v  = sat_s(x_w - PROD_W'(low_q) - bq_v, SVF_W);
    low_v   = sat_s(low_old_w + tdiv_p2(prod_q, 30), SVF_W);
    band_v  = sat_s(band_old_w + tdiv_p2(prod_q, 30), SVF_W);
    sum_v   = PROD_W'(mixacc_q) + prod_q;
    y_v     = sat_s(tdiv_p2(sum_v, 16), SAMPLE_BITS);

    state_d  = state_q;
    x_d      = x_q;
    ch_d     = ch_q;
    last_d   = last_q;
    active_d = active_q;
    env_d    = env_q;
    k_d      = k_q;
    neg_d    = neg_q;
    x2_d     = x2_q;
    hcnt_d   = hcnt_q;
    f_d      = f_q;
    q_d      = q_q;
    low_d    = low_q;
    band_d   = band_q;
    hneg_d   = hneg_q;
    mixacc_d = mixacc_q;
    y_d      = y_q;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d      = in_i.sample_in;
          ch_d     = in_i.channel;
          last_d   = in_i.last_in_block;
          active_d = 32'(in_i.channel) < CHANNELS;
          y_d      = in_i.sample_in;
          state_d  = (32'(in_i.channel) < CHANNELS) ? S_ENV : S_OUT;
        end
      end
      S_ENV: begin
        mul_a   = MUL_W'(coef_w);
        mul_b   = MUL_W'(ax_w - env_old_w);
        state_d = S_ENV2;
      end
      S_ENV2: begin
        env_d   = ENV_W'(env_new);
        mul_a   = MUL_W'(sens_sat);
        mul_b   = MUL_W'(range_q);
        state_d = S_CUT1;
      end
      S_CUT1: begin
        mul_a   = MUL_W'(prod_q);
        mul_b   = MUL_W'(env_q);
        state_d = S_CUT2;
      end
      S_CUT2: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(cut_v <<< 15);
        div_req.divisor  = DIV_VW'(sr_nz);
        state_d          = S_PHASE;
      end
      S_PHASE: begin
        if (div_rsp.done) begin
          k_d     = k_w;
          neg_d   = idx_w[TB+1];
          mul_a   = MUL_W'(k_w);
          mul_b   = MUL_W'(k_w);
          state_d = S_X2;
        end
      end
      S_X2: begin
        x2_d    = X2_W'(x2_v);
        hcnt_d  = '0;
        mul_a   = MUL_W'(HC9);
        mul_b   = MUL_W'(x2_v);
        state_d = S_HORN;
      end
      S_HORN: begin
        mul_a = MUL_W'(acc_v);
        if (hcnt_q != 2'd3) begin
          mul_b  = MUL_W'(x2_q);
          hcnt_d = hcnt_q + 1'b1;
        end else begin
          mul_b   = MUL_W'(xk_v);
          state_d = S_SIN;
        end
      end
      S_SIN: begin
        f_d = F_W'(f_v);
        q_d = Q_W'(q_v);
        if (f_v == 0) begin
          state_d = S_SVF0;
        end else begin
          mul_a   = MUL_W'(f_v);
          mul_b   = MUL_W'(f_v);
          state_d = S_QM;
        end
      end
      S_QM: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(dq_v);
        div_req.divisor  = DIV_VW'(dvs_v);
        state_d          = S_QMW;
      end
      S_QMW: begin
        if (div_rsp.done) begin
          if (DIV_DW'(q_q) > div_rsp.quotient) begin
            q_d = Q_W'(div_rsp.quotient);
          end
          state_d = S_SVF0;
        end
      end
      S_SVF0: begin
        mul_a   = MUL_W'(f_q);
        mul_b   = MUL_W'(band_old_w);
        state_d = S_LOW;
      end
      S_LOW: begin
        low_d            = SVF_W'(low_v);
        hneg_d           = band_old_w < 0;
        div_req.start    = 1'b1;
        div_req.dividend = DIV_DW'(babs_v << 16);
        div_req.divisor  = DIV_VW'(q_q);
        state_d          = S_HW;
      end
      S_HW: begin
        if (div_rsp.done) begin
          mul_a   = MUL_W'(f_q);
          mul_b   = MUL_W'(high_v);
          state_d = S_BAND;
        end
      end
      S_BAND: begin
        band_d  = SVF_W'(band_v);
        mul_a   = MUL_W'(x_q);
        mul_b   = MUL_W'(ONE_Q16 - mix_sat);
        state_d = S_MIX1;
      end
      S_MIX1: begin
        mixacc_d = MIX_W'(prod_q);
        mul_a    = MUL_W'(band_q);
        mul_b    = MUL_W'(mix_sat);
        state_d  = S_MIX2;
      end
      S_MIX2: begin
        y_d     = SAMPLE_BITS'(y_v);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      attack_q     <= CFG_W'(34915);
      release_q    <= CFG_W'(3495);
      sens_q       <= 17'd32768;
      base_q       <= 10'd200;
      range_q      <= 13'd2000;
      resq_q       <= 12'd512;
      mix_q        <= 17'd65536;
      srate_q      <= 18'd48000;
      for (int i = 0; i < CHANNELS; i++) begin
        env_mem_q[i]  <= '0;
        low_mem_q[i]  <= '0;
        band_mem_q[i] <= '0;
      end
      peak_q       <= '0;
      fresh_q      <= 1'b1;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_ch_q     <= 1'b0;
      out_meter_q  <= '0;
      out_done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ATTACK:  attack_q  <= cfg_wdata_i;
          REG_RELEASE: release_q <= cfg_wdata_i;
          REG_SENS:    sens_q    <= cfg_wdata_i[16:0];
          REG_BASE:    base_q    <= cfg_wdata_i[9:0];
          REG_RANGE:   range_q   <= cfg_wdata_i[12:0];
          REG_RESQ:    resq_q    <= cfg_wdata_i[11:0];
          REG_MIX:     mix_q     <= cfg_wdata_i[16:0];
          REG_SRATE:   srate_q   <= cfg_wdata_i[17:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q  <= 1'b1;
        out_sample_q <= y_q;
        out_ch_q     <= ch_q;
        out_meter_q  <= peak_next;
        out_done_q   <= last_q;
        if (active_q) begin
          env_mem_q[ch_idx]  <= env_q;
          low_mem_q[ch_idx]  <= low_q;
          band_mem_q[ch_idx] <= band_q;
          if (!ch_q) begin
            peak_q  <= peak_next;
            fresh_q <= last_q;
          end
        end
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    ch_q     <= ch_d;
    last_q   <= last_d;
    active_q <= active_d;
    env_q    <= env_d;
    k_q      <= k_d;
    neg_q    <= neg_d;
    x2_q     <= x2_d;
    hcnt_q   <= hcnt_d;
    f_q      <= f_d;
    q_q      <= q_d;
    low_q    <= low_d;
    band_q   <= band_d;
    hneg_q   <= hneg_d;
    mixacc_q <= mixacc_d;
    y_q      <= y_d;
    prod_q   <= prod_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.channel_out = out_ch_q;
  assign out_o.meter_level = out_meter_q;
  assign out_o.block_done  = out_done_q;

endmodule

@@ rtl/core/awe_checker.sv @@
module awe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // one sample in flight: no new transaction right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a sample is in flight");

  // a result is loaded only while the input side is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while input was open");

  // a pending result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("pending result dropped");

endmodule

bind auto_wah_envelope_svf awe_checker u_awe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
